// ===== hdl/pulse_width_capture_framer_assert.svh =====
// Assertion macros for the pulse width capture framer checker
`ifndef PULSE_WIDTH_CAPTURE_FRAMER_ASSERT_SVH
`define PULSE_WIDTH_CAPTURE_FRAMER_ASSERT_SVH

// same-cycle implication
`define PWCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PWCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pwcf_pkg.sv =====
// Types and constants shared by the pulse width capture framer
`default_nettype none
package pwcf_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEVEL  = 2'd2;

  localparam logic [31:0] IDLE_TIME_RST   = 32'd10000;
  localparam logic [31:0] FILTER_TIME_RST = 32'd50;
  localparam logic        INIT_LEVEL_RST  = 1'b1;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        pin_level;
    logic [31:0] time_us;
  } pwcf_in_t;

  typedef struct packed {
    logic signed [31:0] duration;
    logic               has_data;
    logic               is_last;
    logic               overflow_seen;
  } pwcf_out_t;

endpackage
`default_nettype wire

// ===== hdl/pwcf_ram.sv =====
// Pulse store: one write port, one registered read port
`default_nettype none
module pwcf_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pulse_width_capture_framer.sv =====
// Top level of the pulse width capture framer
//
//  channel | ports                      | carries
//  --------+----------------------------+-----------------------------------
//  input   | in_valid in_ready in_data  | edge or poll item (pwcf_in_t)
//  output  | out_valid out_ready out_data| one duration beat (pwcf_out_t)
//  config  | cfg_wr_en cfg_index cfg_data| register write, no wait
//
// Edge item: IDLE then EVAL, plus STORE when a pulse is committed (one store write).
// Poll item: IDLE, EVAL, 0 to 2 flush writes in STORE, then START and readout at one
// beat per cycle from the registered store read port; out_ready low holds readout.
// Reset is synchronous and needs no clearing pass; unwritten store entries
// read as anything. in_ready is high only between items.
`default_nettype none
module pulse_width_capture_framer #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pwcf_pkg::pwcf_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pwcf_pkg::pwcf_out_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [pwcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import pwcf_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] i);
    nxt_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  logic [2:0]    state_r, state_nxt;
  pwcf_in_t      item_r, item_nxt;
  logic [31:0]   idle_time_r, idle_time_nxt;
  logic [31:0]   filter_time_r, filter_time_nxt;
  logic [IW-1:0] wi_r, wi_nxt;
  logic [IW-1:0] ri_r, ri_nxt;
  logic [IW-1:0] fsi_r, fsi_nxt;
  logic          ovf_flag_r, ovf_flag_nxt;
  logic [31:0]   prev_time_r, prev_time_nxt;
  logic          prev_level_r, prev_level_nxt;
  logic [31:0]   commit_time_r, commit_time_nxt;
  logic          com_level_r, com_level_nxt;
  logic [31:0]   delta_r, delta_nxt;
  logic          lvl_r, lvl_nxt;
  logic          flush_pend_r, flush_pend_nxt;
  logic          ovf_seen_r, ovf_seen_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic [IW-1:0] iss_idx_r, iss_idx_nxt;
  logic [IW-1:0] iss_cnt_r, iss_cnt_nxt;
  logic          iss_more_r, iss_more_nxt;
  logic          q_vld_r, q_vld_nxt;
  logic [IW-1:0] q_idx_r, q_idx_nxt;
  logic [IW-1:0] q_cnt_r, q_cnt_nxt;
  logic          first_r, first_nxt;
  logic          out_valid_r, out_valid_nxt;
  pwcf_out_t     out_data_r, out_data_nxt;

  logic          mem_wr_en;
  logic [31:0]   mem_wr_data;
  logic          rd_en;
  logic [31:0]   q_data;

  logic [31:0]   since_prev;
  logic          cur_level;
  logic          out_free;
  logic [31:0]   q_mag;
  logic          q_stop;
  logic          q_moves;
  logic [IW-1:0] w_idx;

  pwcf_ram #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wi_r),
    .wr_data (mem_wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss_idx_r),
    .rd_data (q_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign since_prev  = item_r.time_us - prev_time_r;
  assign cur_level   = ~item_r.pin_level;
  assign out_free    = !out_valid_r || out_ready;
  assign mem_wr_data = lvl_r ? delta_r : (32'd0 - delta_r);
  assign q_mag       = q_data[31] ? (32'd0 - q_data) : q_data;
  assign q_stop      = (q_idx_r == last_r) || (q_cnt_r == LAST_IDX) ||
                       (q_mag >= idle_time_r);
  assign q_moves     = (state_r == ST_READ) && q_vld_r && out_free;
  assign rd_en       = (state_r == ST_READ) && iss_more_r &&
                       (!q_vld_r || (q_moves && !q_stop));

  always_comb begin
    state_nxt        = state_r;
    item_nxt         = item_r;
    idle_time_nxt    = idle_time_r;
    filter_time_nxt  = filter_time_r;
    wi_nxt           = wi_r;
    ri_nxt           = ri_r;
    fsi_nxt          = fsi_r;
    ovf_flag_nxt     = ovf_flag_r;
    prev_time_nxt    = prev_time_r;
    prev_level_nxt   = prev_level_r;
    commit_time_nxt  = commit_time_r;
    com_level_nxt    = com_level_r;
    delta_nxt        = delta_r;
    lvl_nxt          = lvl_r;
    flush_pend_nxt   = flush_pend_r;
    ovf_seen_nxt     = ovf_seen_r;
    last_nxt         = last_r;
    iss_idx_nxt      = iss_idx_r;
    iss_cnt_nxt      = iss_cnt_r;
    iss_more_nxt     = iss_more_r;
    q_vld_nxt        = q_vld_r;
    q_idx_nxt        = q_idx_r;
    q_cnt_nxt        = q_cnt_r;
    first_nxt        = first_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    mem_wr_en        = 1'b0;
    w_idx            = nxt_idx(wi_r);

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDLE_TIME:   idle_time_nxt = cfg_data;
        CFG_FILTER_TIME: filter_time_nxt = cfg_data;
        CFG_INIT_LEVEL: begin
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (item_r.kind == KIND_EDGE) begin
          prev_time_nxt  = item_r.time_us;
          prev_level_nxt = cur_level;
          state_nxt      = ST_IDLE;
          if ((since_prev >= filter_time_r) && (prev_level_r != cur_level) &&
              (prev_level_r != com_level_r)) begin
            delta_nxt        = prev_time_r - commit_time_r;
            lvl_nxt          = prev_level_r;
            commit_time_nxt  = prev_time_r;
            com_level_nxt    = prev_level_r;
            flush_pend_nxt   = 1'b0;
            state_nxt        = ST_STORE;
          end
        end else begin
          ovf_seen_nxt = ovf_flag_r;
          ovf_flag_nxt = 1'b0;
          state_nxt    = ST_START;
          if ((fsi_r == ri_r) && (wi_r != fsi_r) && (since_prev >= idle_time_r)) begin
            state_nxt = ST_STORE;
            if (prev_level_r != com_level_r) begin
              delta_nxt        = prev_time_r - commit_time_r;
              lvl_nxt          = prev_level_r;
              commit_time_nxt  = prev_time_r;
              com_level_nxt    = prev_level_r;
              flush_pend_nxt   = 1'b1;
            end else begin
              delta_nxt      = idle_time_r;
              lvl_nxt        = ~com_level_r;
              flush_pend_nxt = 1'b0;
            end
          end
        end
      end
      ST_STORE: begin
        mem_wr_en = 1'b1;
        if (w_idx == ri_r) begin
          w_idx        = fsi_r;
          ovf_flag_nxt = 1'b1;
        end
        if (delta_r >= idle_time_r) begin
          if (wi_r == fsi_r) begin
            w_idx = fsi_r;
          end else begin
            fsi_nxt = w_idx;
          end
        end
        wi_nxt = w_idx;
        if (flush_pend_r) begin
          // idle marker closing the flushed frame
          delta_nxt      = idle_time_r;
          lvl_nxt        = ~com_level_r;
          flush_pend_nxt = 1'b0;
        end else if (item_r.kind == KIND_POLL) begin
          state_nxt = ST_START;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_START: begin
        last_nxt = fsi_r;
        if (fsi_r == ri_r) begin
          state_nxt = ST_EMPTY;
        end else begin
          iss_idx_nxt  = ri_r;
          iss_cnt_nxt  = '0;
          iss_more_nxt = 1'b1;
          first_nxt    = 1'b1;
          q_vld_nxt    = 1'b0;
          state_nxt    = ST_READ;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.duration      = '0;
          out_data_nxt.has_data      = 1'b0;
          out_data_nxt.is_last       = 1'b1;
          out_data_nxt.overflow_seen = ovf_seen_r;
          state_nxt                  = ST_IDLE;
        end
      end
      ST_READ: begin
        if (rd_en) begin
          iss_idx_nxt = nxt_idx(iss_idx_r);
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          q_idx_nxt   = iss_idx_r;
          q_cnt_nxt   = iss_cnt_r;
          if ((iss_idx_r == last_r) || (iss_cnt_r == LAST_IDX)) begin
            iss_more_nxt = 1'b0;
          end
          q_vld_nxt = 1'b1;
        end else if (q_moves) begin
          q_vld_nxt = 1'b0;
        end
        if (q_moves) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.duration      = $signed(q_data);
          out_data_nxt.has_data      = 1'b1;
          out_data_nxt.is_last       = q_stop;
          out_data_nxt.overflow_seen = first_r & ovf_seen_r;
          first_nxt                  = 1'b0;
          if (q_stop) begin
            ri_nxt       = nxt_idx(q_idx_r);
            iss_more_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idle_time_r    <= IDLE_TIME_RST;
      filter_time_r  <= FILTER_TIME_RST;
      wi_r           <= '0;
      ri_r           <= '0;
      fsi_r          <= '0;
      ovf_flag_r     <= 1'b0;
      prev_time_r    <= '0;
      prev_level_r   <= INIT_LEVEL_RST;
      commit_time_r  <= '0;
      com_level_r    <= INIT_LEVEL_RST;
      flush_pend_r   <= 1'b0;
      iss_more_r     <= 1'b0;
      q_vld_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      idle_time_r    <= idle_time_nxt;
      filter_time_r  <= filter_time_nxt;
      wi_r           <= wi_nxt;
      ri_r           <= ri_nxt;
      fsi_r          <= fsi_nxt;
      ovf_flag_r     <= ovf_flag_nxt;
      prev_time_r    <= prev_time_nxt;
      prev_level_r   <= prev_level_nxt;
      commit_time_r  <= commit_time_nxt;
      com_level_r    <= com_level_nxt;
      flush_pend_r   <= flush_pend_nxt;
      iss_more_r     <= iss_more_nxt;
      q_vld_r        <= q_vld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    delta_r    <= delta_nxt;
    lvl_r      <= lvl_nxt;
    ovf_seen_r <= ovf_seen_nxt;
    last_r     <= last_nxt;
    iss_idx_r  <= iss_idx_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    q_idx_r    <= q_idx_nxt;
    q_cnt_r    <= q_cnt_nxt;
    first_r    <= first_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/pwcf_checker.sv =====
// Port-level assertions for the pulse width capture framer, with bind
`default_nettype none
`include "pulse_width_capture_framer_assert.svh"
module pwcf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input pwcf_pkg::pwcf_in_t             in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input pwcf_pkg::pwcf_out_t            out_data,
  input logic                           cfg_wr_en,
  input logic [pwcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                    cfg_data
);
  import pwcf_pkg::*;

  logic edge_beat;
  logic cfg_any;

  assign edge_beat = in_valid && in_ready && (in_data.kind == KIND_EDGE);
  // config activity is not checked here
  assign cfg_any   = cfg_wr_en && ((cfg_index != CFG_IDLE_TIME) || (cfg_data == '0));

  `PWCF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")
  `PWCF_ASSERT_NOW(a_empty_beat, out_valid && !out_data.has_data, out_data.is_last && (out_data.duration == 0), "empty beat must be a lone last beat")
  `PWCF_ASSERT_NXT(a_edge_silent, edge_beat && !cfg_any, !$rose(out_valid), "edge item produced an output beat")
  `PWCF_ASSERT_NXT(a_ovf_first, out_valid && out_ready && !out_data.is_last, !(out_valid && out_data.overflow_seen), "overflow flag on a later beat of a frame")

endmodule

bind pulse_width_capture_framer pwcf_checker u_pwcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_wr_en (cfg_wr_en),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
`default_nettype wire
